@@ rtl/quaternion_to_euler_angles_unit_defines.svh @@
// assertion macros for the quaternion to euler angles unit
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define QTE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qte assertion failed");
// next-cycle implication
`define QTE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qte assertion failed");
`else
`define QTE_ASSERT_IMP(lbl, ante, cons)
`define QTE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/qte_pkg.sv @@
// shared types, constants and the arctangent table
package qte_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int ANGLE_WIDTH     = 16;
    localparam int CORDIC_STAGES   = 16;
    localparam int FRAC_BITS       = COMPONENT_WIDTH - 2;
    localparam int PRESCALE        = 8;
    localparam int SQ_GUARD        = (62 - 2 * FRAC_BITS) / 2;
    localparam int XW              = 44;   // cordic datapath width
    localparam int ZW              = 34;   // angle accumulator, pi = 2^31
    localparam int ANGLE_SHIFT     = 32 - ANGLE_WIDTH;

    localparam logic signed [ZW-1:0] HALF_PI_FINE = ZW'(64'sd1073741824);

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] quat_w;
        logic signed [COMPONENT_WIDTH-1:0] quat_x;
        logic signed [COMPONENT_WIDTH-1:0] quat_y;
        logic signed [COMPONENT_WIDTH-1:0] quat_z;
    } quat_t;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] roll_angle;
        logic signed [ANGLE_WIDTH-1:0] pitch_angle;
        logic signed [ANGLE_WIDTH-1:0] yaw_angle;
        logic                          pitch_clamped;
    } euler_t;

    // atan(2^-i), pi = 2^31
    function automatic logic signed [ZW-1:0] atan_fine(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = ZW'(64'sd536870912);
            1:  v = ZW'(64'sd316933406);
            2:  v = ZW'(64'sd167458907);
            3:  v = ZW'(64'sd85004756);
            4:  v = ZW'(64'sd42667331);
            5:  v = ZW'(64'sd21354465);
            6:  v = ZW'(64'sd10679838);
            7:  v = ZW'(64'sd5340245);
            8:  v = ZW'(64'sd2670163);
            9:  v = ZW'(64'sd1335087);
            10: v = ZW'(64'sd667544);
            11: v = ZW'(64'sd333772);
            12: v = ZW'(64'sd166886);
            13: v = ZW'(64'sd83443);
            14: v = ZW'(64'sd41722);
            15: v = ZW'(64'sd20861);
            16: v = ZW'(64'sd10430);
            17: v = ZW'(64'sd5215);
            18: v = ZW'(64'sd2608);
            19: v = ZW'(64'sd1304);
            20: v = ZW'(64'sd652);
            21: v = ZW'(64'sd326);
            22: v = ZW'(64'sd163);
            23: v = ZW'(64'sd81);
            24: v = ZW'(64'sd41);
            25: v = ZW'(64'sd20);
            26: v = ZW'(64'sd10);
            27: v = ZW'(64'sd5);
            28: v = ZW'(64'sd3);
            29: v = ZW'(64'sd1);
            30: v = ZW'(64'sd1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/qte_cordic.sv @@
// pipelined vectoring cordic, atan2(y, x) as a binary angle
module qte_cordic
(
    input  logic                                     clk,
    input  logic                                     en,
    input  logic signed [qte_pkg::XW-1:0]            y_in,
    input  logic signed [qte_pkg::XW-1:0]            x_in,
    output logic signed [qte_pkg::ANGLE_WIDTH-1:0]   angle
);

    localparam int N = qte_pkg::CORDIC_STAGES;

    logic signed [qte_pkg::XW-1:0] x_reg [0:N];
    logic signed [qte_pkg::XW-1:0] y_reg [0:N];
    logic signed [qte_pkg::ZW-1:0] z_reg [0:N];
    logic                          zero_reg [0:N];

    logic signed [qte_pkg::XW-1:0] xs, ys, x_next, y_next;
    logic signed [qte_pkg::ZW-1:0] z_next, rnd;
    logic signed [qte_pkg::ANGLE_WIDTH-1:0] angle_reg;

    // prescale and fold into the right half plane
    always_comb
    begin
        xs = x_in <<< qte_pkg::PRESCALE;
        ys = y_in <<< qte_pkg::PRESCALE;
        x_next = xs;
        y_next = ys;
        z_next = '0;
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                x_next = ys;
                y_next = -xs;
                z_next = qte_pkg::HALF_PI_FINE;
            end
            else
            begin
                x_next = -ys;
                y_next = xs;
                z_next = -qte_pkg::HALF_PI_FINE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        logic signed [qte_pkg::XW-1:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[i][qte_pkg::XW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + qte_pkg::atan_fine(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - qte_pkg::atan_fine(i);
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // round half up to the output width, wraps
    assign rnd = (zero_reg[N] ? '0 : z_reg[N])
                 + (qte_pkg::ZW'(1) <<< (qte_pkg::ANGLE_SHIFT - 1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= rnd[qte_pkg::ANGLE_SHIFT+qte_pkg::ANGLE_WIDTH-1:qte_pkg::ANGLE_SHIFT];
        end
    end

    assign angle = angle_reg;

endmodule

@@ rtl/quaternion_to_euler_angles_unit.sv @@
// quaternion to roll, pitch, yaw converter, fully pipelined
//
//  channel | valid        | stall        | word
//  --------+--------------+--------------+-----------------------------
//  quat    | quat_valid   | quat_stall   | quat   (w, x, y, z, Q1.14)
//  angles  | angles_valid | angles_stall | angles (roll, pitch, yaw, flag)
//
// one word enters per cycle while the pipeline is not stalled
// pipeline: 3 arithmetic stages, 32 square root stages (one root bit each),
//   1 cordic fold stage, 16 cordic micro-rotations, 1 rounding stage
// a stalled result freezes the whole pipeline; quat_stall follows it
// reset clears only the valid bits; the datapath registers are not reset
`include "quaternion_to_euler_angles_unit_defines.svh"

module quaternion_to_euler_angles_unit
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            quat_valid,
    output logic            quat_stall,
    input  qte_pkg::quat_t  quat,
    output logic            angles_valid,
    input  logic            angles_stall,
    output qte_pkg::euler_t angles
);

    localparam int TPW     = qte_pkg::COMPONENT_WIDTH + 3;   // width of one 2ab term
    localparam int SW      = TPW + 2;                        // width of the sums
    localparam int SQ      = 32;   // square root steps
    localparam int CL      = qte_pkg::CORDIC_STAGES + 2;
    localparam int LATENCY = 3 + SQ + CL;
    localparam int SW_P    = qte_pkg::FRAC_BITS + 1;
    localparam int DW      = 2 * qte_pkg::FRAC_BITS + 1;
    localparam int RW      = DW + 2 * qte_pkg::SQ_GUARD;

    // roll/yaw operands and pitch side info ride along the root stages
    typedef struct packed {
        logic signed [SW-1:0]   sinr;
        logic signed [SW-1:0]   cosr;
        logic signed [SW-1:0]   siny;
        logic signed [SW-1:0]   cosy;
        logic signed [SW_P-1:0] sinp;
        logic                   clamp;
        logic                   neg;
    } side_t;

    logic adv;
    logic [LATENCY-1:0] valid_reg;

    // pipeline moves unless a finished word is held
    assign adv        = !valid_reg[LATENCY-1] || !angles_stall;
    assign quat_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[LATENCY-2:0], quat_valid};
        end
    end

    // stage 1: nine products, each 2ab floored to FRAC_BITS fraction bits
    logic signed [2*qte_pkg::COMPONENT_WIDTH-1:0] p_wx, p_yz, p_xx, p_yy, p_wy;
    logic signed [2*qte_pkg::COMPONENT_WIDTH-1:0] p_zx, p_wz, p_xy, p_zz;
    logic signed [TPW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg;
    logic signed [TPW-1:0] zx_reg, wz_reg, xy_reg, zz_reg;

    assign p_wx = quat.quat_w * quat.quat_x;
    assign p_yz = quat.quat_y * quat.quat_z;
    assign p_xx = quat.quat_x * quat.quat_x;
    assign p_yy = quat.quat_y * quat.quat_y;
    assign p_wy = quat.quat_w * quat.quat_y;
    assign p_zx = quat.quat_z * quat.quat_x;
    assign p_wz = quat.quat_w * quat.quat_z;
    assign p_xy = quat.quat_x * quat.quat_y;
    assign p_zz = quat.quat_z * quat.quat_z;

    localparam int PH = 2 * qte_pkg::COMPONENT_WIDTH - 1;
    localparam int PL = qte_pkg::FRAC_BITS - 1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wx_reg <= p_wx[PH:PL];
            yz_reg <= p_yz[PH:PL];
            xx_reg <= p_xx[PH:PL];
            yy_reg <= p_yy[PH:PL];
            wy_reg <= p_wy[PH:PL];
            zx_reg <= p_zx[PH:PL];
            wz_reg <= p_wz[PH:PL];
            xy_reg <= p_xy[PH:PL];
            zz_reg <= p_zz[PH:PL];
        end
    end

    // stage 2: the five sums and the pitch range check
    localparam logic signed [SW-1:0] ONE = SW'(1) <<< qte_pkg::FRAC_BITS;
    side_t s2_next, s2_reg;
    logic signed [SW-1:0] sinp_full;

    always_comb
    begin
        sinp_full       = SW'(wy_reg) - SW'(zx_reg);
        s2_next.sinr    = SW'(wx_reg) + SW'(yz_reg);
        s2_next.cosr    = ONE - SW'(xx_reg) - SW'(yy_reg);
        s2_next.siny    = SW'(wz_reg) + SW'(xy_reg);
        s2_next.cosy    = ONE - SW'(yy_reg) - SW'(zz_reg);
        s2_next.sinp    = sinp_full[SW_P-1:0];
        s2_next.clamp   = (sinp_full >= ONE) || (sinp_full <= -ONE);
        s2_next.neg     = sinp_full[SW-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg <= s2_next;
        end
    end

    // stage 3: radicand 1 - s^2, valid only when not clamped
    logic signed [2*SW_P-1:0] s_sq;
    logic [DW-1:0] rad;
    logic [RW-1:0] rem_reg [0:SQ];
    logic [RW:0]   res_reg [0:SQ];
    side_t         side_reg [0:SQ];

    assign s_sq = s2_reg.sinp * s2_reg.sinp;
    assign rad  = (DW'(1) << (2 * qte_pkg::FRAC_BITS)) - s_sq[DW-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= {rad, (2 * qte_pkg::SQ_GUARD)'(0)};
            res_reg[0]  <= '0;
            side_reg[0] <= s2_reg;
        end
    end

    // restoring square root, one result bit per stage
    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt
        logic [RW:0] bit_val, trial;
        assign bit_val = (RW+1)'(1) << (RW - 1 - 2 * k);
        assign trial   = res_reg[k] + bit_val;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if ({1'b0, rem_reg[k]} >= trial)
                begin
                    rem_reg[k+1] <= rem_reg[k] - trial[RW-1:0];
                    res_reg[k+1] <= (res_reg[k] >> 1) + bit_val;
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    res_reg[k+1] <= res_reg[k] >> 1;
                end
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // three cordics in step
    logic signed [qte_pkg::XW-1:0] roll_y, roll_x, pitch_y, pitch_x, yaw_y, yaw_x;
    logic signed [qte_pkg::ANGLE_WIDTH-1:0] roll_a, pitch_a, yaw_a;

    assign roll_y  = qte_pkg::XW'(side_reg[SQ].sinr);
    assign roll_x  = qte_pkg::XW'(side_reg[SQ].cosr);
    assign yaw_y   = qte_pkg::XW'(side_reg[SQ].siny);
    assign yaw_x   = qte_pkg::XW'(side_reg[SQ].cosy);
    assign pitch_y = qte_pkg::XW'(side_reg[SQ].sinp) <<< qte_pkg::SQ_GUARD;
    assign pitch_x = signed'({1'b0, res_reg[SQ][qte_pkg::XW-2:0]});

    qte_cordic u_roll
    (
        .clk   (clk),
        .en    (adv),
        .y_in  (roll_y),
        .x_in  (roll_x),
        .angle (roll_a)
    );

    qte_cordic u_pitch
    (
        .clk   (clk),
        .en    (adv),
        .y_in  (pitch_y),
        .x_in  (pitch_x),
        .angle (pitch_a)
    );

    qte_cordic u_yaw
    (
        .clk   (clk),
        .en    (adv),
        .y_in  (yaw_y),
        .x_in  (yaw_x),
        .angle (yaw_a)
    );

    // clamp flag and sign kept in line with the cordic latency
    logic [1:0] flag_reg [0:CL-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flag_reg[0] <= {side_reg[SQ].clamp, side_reg[SQ].neg};
            for (int j = 1; j < CL; j++)
            begin
                flag_reg[j] <= flag_reg[j-1];
            end
        end
    end

    localparam logic signed [qte_pkg::ANGLE_WIDTH-1:0] QUARTER =
        qte_pkg::ANGLE_WIDTH'(1) <<< (qte_pkg::ANGLE_WIDTH - 2);

    // clamped pitch is plus or minus a quarter turn
    always_comb
    begin
        angles.roll_angle    = roll_a;
        angles.yaw_angle     = yaw_a;
        angles.pitch_clamped = flag_reg[CL-1][1];
        if (flag_reg[CL-1][1])
        begin
            angles.pitch_angle = flag_reg[CL-1][0] ? -QUARTER : QUARTER;
        end
        else
        begin
            angles.pitch_angle = pitch_a;
        end
    end

    assign angles_valid = valid_reg[LATENCY-1];

    `QTE_ASSERT_IMP(a_clamp_quarter, angles_valid && angles.pitch_clamped, (angles.pitch_angle == QUARTER) || (angles.pitch_angle == -QUARTER))
    `QTE_ASSERT_IMP(a_stall_cause, quat_stall, angles_valid && angles_stall)
    `QTE_ASSERT_NXT(a_freeze, angles_valid && angles_stall, $stable(valid_reg))

endmodule
